// ===== sv/fpwb_pkg.sv =====
// Shared types and codes for the flash page write-back buffer.
// No dependencies.
`default_nettype none
package fpwb_pkg;
	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_FLUSH = 2'd2,
		REQ_INVAL = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ADDR = 2'd1,
		ST_SKIP = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		COND_CLEAN   = 2'd0,
		COND_DIRTY   = 2'd1,
		COND_INVALID = 2'd2
	} cond_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_PROG,
		S_LOAD,
		S_ACCESS,
		S_DONE
	} fsm_t;
endpackage
`default_nettype wire

// ===== sv/fpwb_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module fpwb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/flash_page_write_back_buffer_top.sv =====
// Top level: one-page write-back buffer in front of a NOR flash array.
// Depends on fpwb_pkg and fpwb_ram.
//
// channel  ports                                           handshake
// request  req_type byte_address write_data final_byte     start & !busy
// result   read_data status page_erased page_programmed    done (one cycle)
//
// Hit, error, skip, invalidate or clean flush: busy in the access and done states after
// the accept, result beat in the cycle after that, which can also accept the next beat.
// A miss on a clean or invalid buffer adds a page load and a second access;
// a dirty write-back adds a check pass and a program pass over the page,
// both through the one flash port.
// The flash array has a valid bit per page; an unprogrammed page reads 0xFF.
// Reset clears control state. The receiver cannot stall results.
`default_nettype none
module flash_page_write_back_buffer_top #(
	parameter int PAGE_BYTES  = 256,
	parameter int FLASH_PAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] byte_address,
	input  wire logic [7:0]  write_data,
	input  wire logic        final_byte,
	output logic             done,
	output logic [7:0]       read_data,
	output logic [1:0]       status,
	output logic             page_erased,
	output logic             page_programmed
);
	import fpwb_pkg::*;

	localparam int PW = $clog2(PAGE_BYTES);
	localparam int GW = (FLASH_PAGES > 1) ? $clog2(FLASH_PAGES) : 1;
	localparam int FD = PAGE_BYTES * FLASH_PAGES;
	localparam int FW = $clog2(FD);

	fsm_t state_q, state_d;
	cond_t cond_q;
	logic [GW-1:0] bpage_q, npage_q;
	logic [PW:0] cnt_q;
	logic [PW-1:0] pos_q;
	logic skip_q;
	req_t req_q;
	logic [7:0] wd_q;
	logic erased_q, prog_q, need_q;
	logic [FLASH_PAGES-1:0] pvalid_q;

	logic buf_we, fl_we;
	logic [PW-1:0] buf_wa, buf_ra;
	logic [7:0] buf_wd, buf_rd;
	logic [FW-1:0] fl_wa, fl_ra;
	logic [7:0] fl_wd, fl_rdm, fl_rd;
	logic rd_pv_q;

	fpwb_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_buf (
		.clk, .we(buf_we), .waddr(buf_wa), .wdata(buf_wd), .raddr(buf_ra), .rdata(buf_rd));
	fpwb_ram #(.WIDTH(8), .DEPTH(FD)) u_flash (
		.clk, .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rdm));

	assign fl_rd = rd_pv_q ? fl_rdm : 8'hFF;

	logic [GW-1:0] in_page;
	logic in_range;
	assign in_range = 32'(byte_address) < 32'(FD);
	assign in_page = GW'(byte_address >> PW);

	logic [PW-1:0] cidx, pidx;
	assign cidx = cnt_q[PW-1:0];
	assign pidx = PW'(cnt_q - 1'b1);
	logic cnt_end, cnt_started;
	assign cnt_end = cnt_q == (PW+1)'(PAGE_BYTES);
	assign cnt_started = cnt_q != '0;

	logic [GW-1:0] fpage;
	assign fpage = (state_q == S_LOAD) ? npage_q : bpage_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_ACCESS;
			S_ACCESS: begin
				if (req_q == REQ_FLUSH) state_d = (cond_q == COND_DIRTY) ? S_CHECK : S_DONE;
				else if (req_q == REQ_INVAL || skip_q || status != ST_OK) state_d = S_DONE;
				else if (cond_q == COND_INVALID) state_d = S_LOAD;
				else if (npage_q != bpage_q)
					state_d = (cond_q == COND_DIRTY) ? S_CHECK : S_LOAD;
				else state_d = S_DONE;
			end
			S_CHECK: if (cnt_end) state_d = S_PROG;
			S_PROG: if (cnt_end) state_d = (req_q == REQ_FLUSH) ? S_DONE : S_LOAD;
			S_LOAD: if (cnt_end) state_d = S_ACCESS;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q != S_IDLE;
		buf_ra = (state_q == S_ACCESS || state_q == S_DONE) ? pos_q : cidx;
		fl_ra = FW'({fpage, cidx});
		buf_we = 1'b0; buf_wa = pidx; buf_wd = fl_rd;
		fl_we = 1'b0; fl_wa = FW'({bpage_q, pidx});
		fl_wd = (need_q ? 8'hFF : fl_rd) & buf_rd;
		case (state_q)
			S_LOAD: buf_we = cnt_started;
			S_PROG: fl_we = cnt_started;
			S_DONE: begin
				buf_we = req_q == REQ_WRITE && status == ST_OK;
				buf_wa = pos_q; buf_wd = wd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; cond_q <= COND_INVALID; bpage_q <= '0; skip_q <= 1'b0;
			cnt_q <= '0; pvalid_q <= '0; done <= 1'b0; status <= ST_OK;
			erased_q <= 1'b0; prog_q <= 1'b0; need_q <= 1'b0; rd_pv_q <= 1'b0;
			req_q <= REQ_READ; npage_q <= '0; pos_q <= '0; wd_q <= '0;
		end else begin
			state_q <= state_d;
			done <= state_q == S_DONE;
			rd_pv_q <= pvalid_q[fpage];
			if (state_q != state_d) cnt_q <= '0;
			else if (state_q == S_CHECK || state_q == S_PROG || state_q == S_LOAD)
				cnt_q <= cnt_q + 1'b1;
			case (state_q)
				S_IDLE: if (start) begin
					req_q <= req_t'(req_type); npage_q <= in_page;
					pos_q <= PW'(byte_address); wd_q <= write_data;
					erased_q <= 1'b0; prog_q <= 1'b0; need_q <= 1'b0;
					status <= ST_OK;
					if (req_type == REQ_FLUSH) skip_q <= 1'b0;
					else if (req_type == REQ_INVAL) begin
						skip_q <= 1'b0; cond_q <= COND_INVALID; bpage_q <= '0;
					end else if (skip_q) begin
						status <= ST_SKIP;
						if (final_byte) skip_q <= 1'b0;
					end else if (!in_range) begin
						status <= ST_ADDR; skip_q <= !final_byte;
					end
				end
				S_ACCESS: if (req_q == REQ_INVAL) skip_q <= 1'b0;
				S_CHECK: if (cnt_started && ((~fl_rd & buf_rd) != 8'h00)) need_q <= 1'b1;
				S_PROG: if (cnt_end) begin
					cond_q <= COND_CLEAN; prog_q <= 1'b1; erased_q <= need_q;
					pvalid_q[bpage_q] <= 1'b1;
				end
				S_LOAD: if (cnt_end) begin
					cond_q <= COND_CLEAN; bpage_q <= npage_q;
				end
				S_DONE: if (req_q == REQ_WRITE && status == ST_OK) cond_q <= COND_DIRTY;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			read_data <= (req_q == REQ_READ && status == ST_OK) ? buf_rd : 8'h00;
			page_erased <= erased_q;
			page_programmed <= prog_q;
		end
	end

	property p_no_start_busy;
		@(posedge clk) disable iff (!arst_n) busy |=> !(state_q == S_IDLE && $past(state_q) == S_IDLE);
	endproperty
	a_busy: assert property (p_no_start_busy) else $error("busy dropped early");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_DONE) else $error("done without item");
	a_prog: assert property (@(posedge clk) disable iff (!arst_n)
		fl_we |-> cond_q == COND_DIRTY) else $error("program of clean page");
	a_erase: assert property (@(posedge clk) disable iff (!arst_n)
		(done && page_erased) |-> page_programmed) else $error("erase without program");
endmodule
`default_nettype wire
